// ===== hdl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// shared constants, codes and controller/datapath interface types for the
// deadline timer queue
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int unsigned TIMER_SLOTS        = 64;
	localparam int unsigned MAX_FIRES_PER_TICK = 16;
	localparam int unsigned RESULT_LIMIT       = 16;
	localparam int unsigned FIRE_LIMIT         =
		(MAX_FIRES_PER_TICK < RESULT_LIMIT) ? MAX_FIRES_PER_TICK : RESULT_LIMIT;

	localparam int unsigned IDX_W   = $clog2(TIMER_SLOTS);
	localparam int unsigned CNT_W   = $clog2(FIRE_LIMIT + 1);
	localparam int unsigned TIME_W  = 48;
	localparam int unsigned WAIT_W  = 49;
	localparam int unsigned ID_W    = 32;
	localparam int unsigned PER_W   = 32;
	localparam int unsigned ENTRY_W = TIME_W + PER_W + ID_W;

	typedef enum logic [1:0] {
		CMD_SCHED_ABS   = 2'd0,
		CMD_SCHED_DELAY = 2'd1,
		CMD_CANCEL      = 2'd2,
		CMD_TICK        = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_EMIT,
		ST_FIRE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic scan_start;
		logic fire;
		logic out_load;
		logic out_fired;
		logic out_last;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic scan_busy;
		logic expired;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hdl/dtq_dp.sv =====
// ----------------------------------------------------------------------------
// dtq_dp
// timer table memory, sequential slot scan, re-arm arithmetic and result
// register
// ----------------------------------------------------------------------------
module dtq_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dtq_pkg::ctrl_cmd_t              ctl,
	output dtq_pkg::dp_status_t             sts,
	input  logic [1:0]                      command,
	input  logic [dtq_pkg::TIME_W-1:0]      now_time,
	input  logic [dtq_pkg::TIME_W-1:0]      time_value,
	input  logic [dtq_pkg::PER_W-1:0]       period,
	input  logic [dtq_pkg::ID_W-1:0]        cancel_id,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [1:0]                      status,
	output logic [dtq_pkg::ID_W-1:0]        entry_id,
	output logic                            fired,
	output logic signed [dtq_pkg::WAIT_W-1:0] wait_time,
	output logic                            last
);
	import dtq_pkg::*;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

	// captured item
	cmd_t              cmd_q;
	logic [TIME_W-1:0] now_q, tval_q, new_dl_q;
	logic [PER_W-1:0]  period_q;
	logic [ID_W-1:0]   cancel_q;

	logic [TIMER_SLOTS-1:0] valid_q;
	logic [ID_W-1:0]        seq_q;
	logic [ENTRY_W-1:0]     slot_mem_q [TIMER_SLOTS];

	// scan pipeline
	logic               scan_run_q;
	logic [IDX_W-1:0]   scan_addr_q;
	logic               rd_valid_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [ENTRY_W-1:0] rd_entry_s1;
	logic [TIME_W-1:0]  rd_dl;
	logic [PER_W-1:0]   rd_per;
	logic [ID_W-1:0]    rd_id;
	logic               rd_live, rd_match;

	// scan results
	logic               best_found_q;
	logic [TIME_W-1:0]  best_dl_q;
	logic [PER_W-1:0]   best_per_q;
	logic [ID_W-1:0]    best_id_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic               match_found_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [ID_W-1:0]    fire_id_q;

	// write port
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic [ENTRY_W-1:0] wr_entry;
	logic               sched_commit, cancel_commit, is_sched;

	// result
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [ID_W-1:0]    entry_id_q;
	logic               fired_q, last_q;
	logic [WAIT_W-1:0]  wait_q;
	logic               eff_found;
	logic [TIME_W-1:0]  eff_dl;
	status_t            res_status;
	logic [ID_W-1:0]    res_id;

	assign is_sched      = (cmd_q == CMD_SCHED_ABS) || (cmd_q == CMD_SCHED_DELAY);
	assign sched_commit  = ctl.out_load && is_sched && free_found_q;
	assign cancel_commit = ctl.out_load && (cmd_q == CMD_CANCEL) && match_found_q;

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q    <= cmd_t'(command);
			now_q    <= now_time;
			tval_q   <= time_value;
			period_q <= period;
			cancel_q <= cancel_id;
		end
		new_dl_q <= (cmd_q == CMD_SCHED_ABS) ? tval_q : sat_add(now_q, tval_q);
	end

	// memory write
	always_comb begin
		wr_en    = 1'b0;
		wr_idx   = free_idx_q;
		wr_entry = {new_dl_q, (cmd_q == CMD_SCHED_ABS) ? {PER_W{1'b0}} : period_q, seq_q};
		if (ctl.fire) begin
			wr_en    = (best_per_q != '0);
			wr_idx   = best_idx_q;
			wr_entry = {sat_add(best_dl_q, {{(TIME_W-PER_W){1'b0}}, best_per_q}),
				best_per_q, best_id_q};
		end else if (sched_commit) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem_q[wr_idx] <= wr_entry;
		end
		rd_entry_s1 <= slot_mem_q[scan_addr_q];
		rd_idx_s1   <= scan_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			seq_q   <= '0;
		end else begin
			if (ctl.fire && (best_per_q == '0)) begin
				valid_q[best_idx_q] <= 1'b0;
			end
			if (sched_commit) begin
				valid_q[free_idx_q] <= 1'b1;
				seq_q               <= seq_q + 1'b1;
			end
			if (cancel_commit) begin
				valid_q[match_idx_q] <= 1'b0;
			end
		end
	end

	// scan address sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_run_q  <= 1'b0;
			scan_addr_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= scan_run_q && !ctl.scan_start;
			if (ctl.scan_start) begin
				scan_run_q  <= 1'b1;
				scan_addr_q <= '0;
			end else if (scan_run_q) begin
				scan_addr_q <= scan_addr_q + 1'b1;
				if (scan_addr_q == IDX_W'(TIMER_SLOTS - 1)) begin
					scan_run_q <= 1'b0;
				end
			end
		end
	end

	assign rd_dl    = rd_entry_s1[ENTRY_W-1 -: TIME_W];
	assign rd_per   = rd_entry_s1[ID_W +: PER_W];
	assign rd_id    = rd_entry_s1[ID_W-1:0];
	assign rd_live  = valid_q[rd_idx_s1];
	// the first matching timer of a cancel is left out of the minimum
	assign rd_match = rd_live && (cmd_q == CMD_CANCEL) && (rd_id == cancel_q)
		&& !match_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (ctl.scan_start) begin
			best_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (rd_valid_s1) begin
			if (!rd_live && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (rd_match) begin
				match_found_q <= 1'b1;
			end else if (rd_live && (!best_found_q || (rd_dl < best_dl_q))) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1 && !ctl.scan_start) begin
			if (!rd_live && !free_found_q) begin
				free_idx_q <= rd_idx_s1;
			end
			if (rd_match) begin
				match_idx_q <= rd_idx_s1;
			end else if (rd_live && (!best_found_q || (rd_dl < best_dl_q))) begin
				best_dl_q  <= rd_dl;
				best_per_q <= rd_per;
				best_id_q  <= rd_id;
				best_idx_q <= rd_idx_s1;
			end
		end
		if (ctl.fire) begin
			fire_id_q <= best_id_q;
		end
	end

	// result selection
	always_comb begin
		eff_found = best_found_q;
		eff_dl    = best_dl_q;
		if (is_sched && free_found_q) begin
			eff_found = 1'b1;
			if (!best_found_q || (new_dl_q < best_dl_q)) begin
				eff_dl = new_dl_q;
			end
		end
		res_status = STS_OK;
		res_id     = '0;
		unique case (cmd_q)
			CMD_SCHED_ABS, CMD_SCHED_DELAY: begin
				res_status = free_found_q ? STS_OK : STS_FULL;
				res_id     = free_found_q ? seq_q : '0;
			end
			CMD_CANCEL: begin
				res_status = match_found_q ? STS_OK : STS_NOT_FOUND;
				res_id     = cancel_q;
			end
			CMD_TICK: begin
				res_id = ctl.out_fired ? fire_id_q : '0;
			end
			default: begin
				res_id = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			status_q   <= res_status;
			entry_id_q <= res_id;
			fired_q    <= ctl.out_fired;
			last_q     <= ctl.out_last;
			wait_q     <= eff_found ? ({1'b0, eff_dl} - {1'b0, now_q}) : {WAIT_W{1'b1}};
		end
	end

	assign sts.cmd       = cmd_q;
	assign sts.scan_busy = scan_run_q || rd_valid_s1;
	assign sts.expired   = best_found_q && (best_dl_q <= now_q);
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign entry_id  = entry_id_q;
	assign fired     = fired_q;
	assign wait_time = $signed(wait_q);
	assign last      = last_q;

endmodule

// ===== hdl/dtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtq_ctrl
// command sequencer: scan, decide, fire and result hand-off
// ----------------------------------------------------------------------------
module dtq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dtq_pkg::dp_status_t sts,
	output dtq_pkg::ctrl_cmd_t  ctl
);
	import dtq_pkg::*;

	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] fires_q;
	logic             any_fired, more;

	assign any_fired = (fires_q != '0);
	assign more      = sts.expired && (fires_q < CNT_W'(FIRE_LIMIT));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (!sts.scan_busy) state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if ((sts.cmd == CMD_TICK) && !any_fired && sts.expired) begin
					state_nxt = ST_FIRE;
				end else begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_nxt = ((sts.cmd == CMD_TICK) && any_fired && more) ? ST_FIRE : ST_IDLE;
				end
			end
			ST_FIRE: begin
				state_nxt = ST_SCAN;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl            = '0;
		ctl.out_fired  = any_fired;
		ctl.out_last   = !((sts.cmd == CMD_TICK) && any_fired && more);
		unique case (state_q)
			ST_IDLE: begin
				ctl.load_in    = in_valid;
				ctl.scan_start = in_valid;
			end
			ST_EMIT: begin
				ctl.out_load = sts.out_free;
			end
			ST_FIRE: begin
				ctl.fire       = 1'b1;
				ctl.scan_start = 1'b1;
			end
			default: begin
				ctl.load_in = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fires_q <= '0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == ST_IDLE) && in_valid) begin
				fires_q <= '0;
			end else if (state_q == ST_FIRE) begin
				fires_q <= fires_q + 1'b1;
			end
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ===== hdl/deadline_timer_queue_unit.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit
// fixed table of deadline timers with schedule, cancel and tick commands
// ----------------------------------------------------------------------------
// One command is taken at a time. Every command makes one full pass over the
// timer table, one slot a cycle through the table memory's single read port,
// from scan start to decision. A tick that fires n timers makes one further
// pass per fire (re-arm or free, then a rescan that gives the next candidate
// and the wait), with at most FIRE_LIMIT fires (16). A stalled result
// register holds off the loading of each result until it is free. The final
// result waits in the output register, so the next command is taken while it
// is still stalled downstream.
// ----------------------------------------------------------------------------
module deadline_timer_queue_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// command transfer
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        command,
	input  logic [dtq_pkg::TIME_W-1:0]        now_time,
	input  logic [dtq_pkg::TIME_W-1:0]        time_value,
	input  logic [dtq_pkg::PER_W-1:0]         period,
	input  logic [dtq_pkg::ID_W-1:0]          cancel_id,
	// result transfer
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [dtq_pkg::ID_W-1:0]          entry_id,
	output logic                              fired,
	output logic signed [dtq_pkg::WAIT_W-1:0] wait_time,
	output logic                              last
);
	import dtq_pkg::*;

	ctrl_cmd_t  ctl;
	dp_status_t sts;

	// sequencer: idle, scan, decide, fire and emit
	dtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	// table memory, scan and result register
	dtq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.command    (command),
		.now_time   (now_time),
		.time_value (time_value),
		.period     (period),
		.cancel_id  (cancel_id),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.status     (status),
		.entry_id   (entry_id),
		.fired      (fired),
		.wait_time  (wait_time),
		.last       (last)
	);

	// an accepted command always makes the block busy for its scan
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after command transfer");

	// a fired result always carries ok status
	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fired |-> status == STS_OK)
		else $error("fired result with bad status");

	// only tick fire results are followed by more results
	a_not_last_fired: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> fired)
		else $error("non-final result that is not a fire");

endmodule
